// ----- rtl/zkhm_pkg.sv -----
package zkhm_pkg;

    localparam int SampleW  = 16;
    localparam int PermW    = 16;
    localparam int ProdW    = SampleW + PermW;
    localparam int PressW   = 7;
    localparam int GapW     = 8;
    localparam int ModeW    = 2;
    localparam int CfgIdxW  = 8;

    localparam logic [ModeW-1:0] MODE_IDLE  = 2'd0;
    localparam logic [ModeW-1:0] MODE_SHORT = 2'd1;
    localparam logic [ModeW-1:0] MODE_DONE  = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_SCALE_ENABLE   = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_SCALE_PERMILLE = 8'd1;

    localparam logic [PermW-1:0]   PERMILLE_RESET = 16'd10000;
    localparam logic [PermW-1:0]   PERMILLE_UNITY = 16'd1000;

    localparam logic [PressW-1:0]  PRESS_WRAP_AT   = 7'd100;
    localparam logic [PressW-1:0]  PRESS_WRAP_TO   = 7'd12;
    localparam logic [PressW-1:0]  PRESS_MIN_START = 7'd10;
    localparam logic [PressW-1:0]  PRESS_SHORT_MAX = 7'd10;
    localparam logic [GapW-1:0]    GAP_WRAP_AT     = 8'd200;
    localparam logic [GapW-1:0]    GAP_WRAP_TO     = 8'd10;
    localparam logic [GapW-1:0]    GAP_DOUBLE_MAX  = 8'd8;
    localparam logic [GapW-1:0]    GAP_RESET       = 8'd1;

    // ceil(2^41 / 1000): floor(p / 1000) == (p * RECIP_1000) >> 41 for any 32-bit p
    localparam logic [31:0] RECIP_1000 = 32'd2199023256;
    localparam int          RECIP_SH   = 41;

    localparam logic [SampleW-1:0] MIN_NONE = '1;

    typedef struct packed {
        logic res;
        logic kind;
        logic clear;
        logic upd;
        logic fin;
    } t_ctl;

endpackage

// ----- rtl/zener_key_hold_meter_top.sv -----
// zener key hold meter
// s_axis: one beat per 30 ms tick, tdata = {sample, key_down}; key_down in bit 0.
// m_axis: zero or one beat per tick, tdata = voltage, tuser = {finished,
// value_valid, kind}. kind 0 is a live reading (press count a multiple of 8), kind 1
// the hold report sent on key release, carrying the held minimum.
// cfg: write channel, index 0 scale_enable, index 1 scale_permille; always
// ready, written while no tick is in flight.
// a tick's result is registered at each pipe stage and in the output register.
// throughput: one tick per cycle unless m_axis stalls the pipe; press, gap and
// mode counters update at the input beat, the scaled sample goes through a
// 16x16 multiply and a 32x32 reciprocal multiply for the divide by 1000, then
// the minimum stage. a result stalled on m_axis keeps its output register;
// ticks without a result and bubbles keep flowing, and s_axis_tready drops
// only once the whole pipe is full behind the stalled beat.
// reset: counters cleared, gap count 1, minimum 0xffff, scale_enable 0,
// scale_permille 10000. after a short press and a second press within the gap
// limit end the tool every further tick is taken and dropped until reset.
module zener_key_hold_meter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // key_down, sample, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // voltage
    output logic [2:0]  m_axis_tuser,    // kind, value_valid, finished
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [zkhm_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic                          r_scale_en;
    logic [zkhm_pkg::PermW-1:0]    r_permille;

    logic [zkhm_pkg::PressW-1:0]   r_press, n_press;
    logic [zkhm_pkg::GapW-1:0]     r_gap, n_gap;
    logic [zkhm_pkg::ModeW-1:0]    r_mode, n_mode;

    logic                          r_v1, r_v2, r_v3;
    zkhm_pkg::t_ctl                r_c1, r_c2, r_c3, n_ctl;
    logic                          n_push;
    logic [zkhm_pkg::SampleW-1:0]  r_s1;
    logic [zkhm_pkg::ProdW-1:0]    r_p2;
    logic [zkhm_pkg::SampleW-1:0]  r_q3;
    logic [zkhm_pkg::SampleW-1:0]  r_min;

    logic                          r_out_valid;
    logic [15:0]                   r_out_data;
    logic [2:0]                    r_out_user;

    logic                          a1, a2, a3, in_beat, key;
    logic [zkhm_pkg::PermW-1:0]    factor;
    logic [63:0]                   recip_prod;
    logic                          min_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_en <= 1'b0;
            r_permille <= zkhm_pkg::PERMILLE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                zkhm_pkg::REG_SCALE_ENABLE:   r_scale_en <= i_cfg_data[0];
                zkhm_pkg::REG_SCALE_PERMILLE: r_permille <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipe handshake, a stage moves when the next one is empty or moving
    assign a3 = !r_v3 || !r_c3.res || !r_out_valid || m_axis_tready;
    assign a2 = !r_v2 || a3;
    assign a1 = !r_v1 || a2;
    assign s_axis_tready = a1;
    assign in_beat = s_axis_tvalid && a1;
    assign key = s_axis_tdata[0];

    // tick control at the input beat
    always_comb begin
        n_press = r_press;
        n_gap   = r_gap;
        n_mode  = r_mode;
        n_push  = 1'b0;
        n_ctl   = '0;
        if (!r_mode[1]) begin
            if (key) begin
                n_push     = 1'b1;
                n_ctl.res  = (r_press[2:0] == 3'd0);
                n_ctl.clear = (r_press == '0);
                n_ctl.upd  = (r_press >= zkhm_pkg::PRESS_MIN_START);
                n_press    = (r_press == zkhm_pkg::PRESS_WRAP_AT) ? zkhm_pkg::PRESS_WRAP_TO
                                                                   : r_press + 1'b1;
            end else if (r_press != '0) begin
                if (r_mode == zkhm_pkg::MODE_SHORT) begin
                    n_mode = (r_gap <= zkhm_pkg::GAP_DOUBLE_MAX) ? zkhm_pkg::MODE_DONE
                                                                 : zkhm_pkg::MODE_IDLE;
                end else if (r_press <= zkhm_pkg::PRESS_SHORT_MAX) begin
                    n_mode = zkhm_pkg::MODE_SHORT;
                end
                n_push    = 1'b1;
                n_ctl.res = 1'b1;
                n_ctl.kind = 1'b1;
                n_ctl.fin = (n_mode == zkhm_pkg::MODE_DONE);
                n_press   = '0;
                n_gap     = zkhm_pkg::GAP_RESET;
            end else begin
                n_gap = (r_gap == zkhm_pkg::GAP_WRAP_AT) ? zkhm_pkg::GAP_WRAP_TO
                                                         : r_gap + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press <= '0;
            r_gap   <= zkhm_pkg::GAP_RESET;
            r_mode  <= zkhm_pkg::MODE_IDLE;
        end else if (in_beat) begin
            r_press <= n_press;
            r_gap   <= n_gap;
            r_mode  <= n_mode;
        end
    end

    // scaling: unity factor when disabled gives the sample back exactly
    assign factor     = r_scale_en ? r_permille : zkhm_pkg::PERMILLE_UNITY;
    assign recip_prod = {32'd0, r_p2} * {32'd0, zkhm_pkg::RECIP_1000};
    assign min_valid  = (r_min != zkhm_pkg::MIN_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (a1) r_v1 <= in_beat && n_push;
            if (a2) r_v2 <= r_v1;
            if (a3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a1) begin
            r_c1 <= n_ctl;
            r_s1 <= s_axis_tdata[16:1];
        end
        if (a2) begin
            r_c2 <= r_c1;
            r_p2 <= {16'd0, r_s1} * {16'd0, factor};
        end
        if (a3) begin
            r_c3 <= r_c2;
            r_q3 <= recip_prod[zkhm_pkg::RECIP_SH +: zkhm_pkg::SampleW];
        end
    end

    // minimum tracking and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= zkhm_pkg::MIN_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_v3 && a3 && r_c3.res) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_v3 && a3) begin
                if (r_c3.clear) begin
                    r_min <= zkhm_pkg::MIN_NONE;
                end else if (r_c3.upd && (r_q3 < r_min)) begin
                    r_min <= r_q3;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && a3 && r_c3.res) begin
            if (r_c3.kind) begin
                r_out_data <= min_valid ? r_min : '0;
                r_out_user <= {r_c3.fin, min_valid, 1'b1};
            end else begin
                r_out_data <= r_q3;
                r_out_user <= 3'b010;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- test/tb_zener_key_hold_meter_top.sv -----
module tb_zener_key_hold_meter_top;
    import zkhm_pkg::*;

    typedef struct packed {
        logic               key;
        logic [SampleW-1:0] smp;
    } t_tick;

    typedef struct packed {
        logic               kind;
        logic [SampleW-1:0] voltage;
        logic               value_valid;
        logic               finished;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;
    logic [2:0]         m_axis_tuser;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    t_tick    ticks_pending[$];
    t_reading readings_due[$];
    int       ticks_queued = 0;
    int       errors = 0;

    // meter state as the block should hold it
    logic               scale_en = 1'b0;
    logic [PermW-1:0]   scale_pm = PERMILLE_RESET;
    logic [PressW-1:0]  press_cnt = '0;
    logic [GapW-1:0]    gap_cnt = GAP_RESET;
    logic [ModeW-1:0]   press_mode_q = MODE_IDLE;
    logic [SampleW-1:0] min_held = MIN_NONE;

    // stimulus side view of the double press detector
    int gen_gap = 1;
    bit gen_armed = 1'b0;

    int send_wait = 0;
    int send_calm = 0;
    int recv_wait = 0;
    int recv_calm = 0;

    zener_key_hold_meter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void meter_tick(logic key, logic [SampleW-1:0] smp);
        logic [SampleW-1:0] v;
        logic [ProdW-1:0]   prod;
        t_reading           r;
        if (press_mode_q >= MODE_DONE)
            return;
        if (key) begin
            prod = ProdW'(smp) * ProdW'(scale_pm);
            v = scale_en ? SampleW'(prod / ProdW'(PERMILLE_UNITY)) : smp;
            if (press_cnt[2:0] == 3'd0) begin
                r.kind        = 1'b0;
                r.voltage     = v;
                r.value_valid = 1'b1;
                r.finished    = 1'b0;
                readings_due.push_back(r);
            end
            if (press_cnt == '0)
                min_held = MIN_NONE;
            else if (press_cnt >= PRESS_MIN_START && v < min_held)
                min_held = v;
            press_cnt = (press_cnt == PRESS_WRAP_AT) ? PRESS_WRAP_TO : press_cnt + 1'b1;
            return;
        end
        if (press_cnt != '0) begin
            if (press_mode_q == MODE_SHORT)
                press_mode_q = (gap_cnt <= GAP_DOUBLE_MAX) ? MODE_DONE : MODE_IDLE;
            else if (press_cnt <= PRESS_SHORT_MAX)
                press_mode_q = MODE_SHORT;
            r.kind        = 1'b1;
            r.value_valid = (min_held != MIN_NONE);
            r.voltage     = r.value_valid ? min_held : SampleW'(0);
            r.finished    = (press_mode_q == MODE_DONE);
            readings_due.push_back(r);
            press_cnt = '0;
            gap_cnt   = '0;
        end
        gap_cnt = (gap_cnt == GAP_WRAP_AT) ? GAP_WRAP_TO : gap_cnt + 1'b1;
    endfunction

    // mostly back to back, short gaps, a few long ones, now and then a calm stretch
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm = $urandom_range(30, 150);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [SampleW-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return SampleW'($urandom_range(0, 65535));
    endfunction

    function automatic void push_tick(logic key, logic [SampleW-1:0] smp);
        t_tick t;
        t.key = key;
        t.smp = smp;
        ticks_pending.push_back(t);
        ticks_queued++;
    endfunction

    // key up ticks, a press of len ticks, then the release tick; fill < 0 means random samples
    function automatic void add_press(int ups, int len, bit may_end, int fill);
        while (ups > 0 || (gen_armed && gen_gap <= GAP_DOUBLE_MAX && !may_end)) begin
            push_tick(1'b0, rand_sample());
            if (gen_gap < 255)
                gen_gap++;
            ups--;
        end
        for (int i = 0; i < len; i++)
            push_tick(1'b1, (fill < 0) ? rand_sample() : SampleW'(fill));
        push_tick(1'b0, rand_sample());
        if (gen_armed)
            gen_armed = 1'b0;
        else
            gen_armed = (len <= PRESS_SHORT_MAX);
        gen_gap = 1;
    endfunction

    // checked away from the driving edge so queue and valid reads are settled
    task automatic drain();
        while (ticks_pending.size() != 0 || s_axis_tvalid || readings_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // enable, ratio, then a write to an index past the register list
    task automatic set_scaling(logic en, logic [PermW-1:0] pm);
        logic [CfgIdxW-1:0] idx [3];
        logic [15:0]        dat [3];
        idx[0] = REG_SCALE_ENABLE;
        dat[0] = {15'($urandom), en};
        idx[1] = REG_SCALE_PERMILLE;
        dat[1] = pm;
        idx[2] = CfgIdxW'($urandom_range(2, 255));
        dat[2] = 16'($urandom);
        i_cfg_valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= dat[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            if (idx[k] == REG_SCALE_ENABLE)
                scale_en = dat[k][0];
            else if (idx[k] == REG_SCALE_PERMILLE)
                scale_pm = dat[k];
        end
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_tick t;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                meter_tick(s_axis_tdata[0], s_axis_tdata[16:1]);
                send_wait = idle_len(send_calm);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (ticks_pending.size() != 0) begin
                    t = ticks_pending.pop_front();
                    s_axis_tdata  <= {7'd0, t.smp, t.key};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (readings_due.size() == 0) begin
                    $error("unexpected result beat: voltage %0d tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = readings_due.pop_front();
                    if (m_axis_tuser[0] !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tdata !== want.voltage) begin
                        $error("voltage: expected %0d, got %0d", want.voltage, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== want.value_valid) begin
                        $error("value_valid: expected %0d, got %0d",
                               want.value_valid, m_axis_tuser[1]);
                        errors++;
                    end
                    if (m_axis_tuser[2] !== want.finished) begin
                        $error("finished: expected %0d, got %0d",
                               want.finished, m_axis_tuser[2]);
                        errors++;
                    end
                end
                recv_wait = idle_len(recv_calm);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [PermW-1:0] pm_set [8];
        logic             en_set [8];
        int               stop_at;
        int               r;
        int               ups;
        int               len;
        pm_set = '{PERMILLE_UNITY, 16'hFFFF, 16'd0, 16'd999,
                   16'hFFFF, PERMILLE_RESET, 16'd0, 16'd1};
        en_set = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all ones held, then a one tick press, then a second press one tick past the gap limit
        add_press(0, 11, 1'b0, 16'hFFFF);
        add_press(0, 1, 1'b0, 0);
        add_press(8, 2, 1'b0, 0);
        drain();

        for (int p = 0; p < 8; p++) begin
            set_scaling(en_set[p],
                        (p == 6) ? PermW'($urandom_range(1000, 65535)) : pm_set[p]);
            stop_at = ticks_queued + 160;
            while (ticks_queued < stop_at) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    add_press($urandom_range(0, 2), $urandom_range(1, 2), 1'b0, -1);
                end else begin
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        ups = $urandom_range(0, 3);
                    else if (r < 9)
                        ups = $urandom_range(4, 12);
                    else
                        ups = $urandom_range(13, 250);
                    r = $urandom_range(0, 9);
                    if (r < 3)
                        len = $urandom_range(1, 10);
                    else if (r < 7)
                        len = $urandom_range(11, 40);
                    else if (r < 9)
                        len = $urandom_range(41, 130);
                    else
                        len = $urandom_range(131, 250);
                    add_press(ups, len, 1'b0, -1);
                end
            end
            drain();
        end

        // short press then a second press within the gap limit ends the tool
        add_press(12, 20, 1'b0, -1);
        add_press(12, 4, 1'b0, -1);
        add_press(7, 5, 1'b1, -1);
        for (int i = 0; i < 20; i++)
            push_tick(1'($urandom_range(0, 1)), rand_sample());
        drain();

        if (errors == 0)
            $display("tb_zener_key_hold_meter_top: done, clean");
        else
            $display("tb_zener_key_hold_meter_top: done, errors");
        $finish;
    end

    initial begin
        #8000000;
        $display("tb_zener_key_hold_meter_top: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/zkhm_pkg.sv
rtl/zener_key_hold_meter_top.sv
test/tb_zener_key_hold_meter_top.sv
